>>> rtl/form_field_extract_url_decode_assert.svh
`ifndef FORM_FIELD_EXTRACT_URL_DECODE_ASSERT_SVH
`define FORM_FIELD_EXTRACT_URL_DECODE_ASSERT_SVH

// same-cycle implication
`define FFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ffe_pkg.sv
package ffe_pkg;

  localparam int MAX_KEY_BYTES   = 8;
  localparam int MAX_VALUE_BYTES = 64;
  localparam int RES_DEPTH       = 4;
  localparam int RES_PER_WORD    = 3;

  localparam logic [63:0] KEY_TEXT_RST   = 64'd1684632435;
  localparam logic [3:0]  KEY_LENGTH_RST = 4'd4;
  localparam logic [6:0]  MAX_LENGTH_RST = 7'd32;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;

  typedef enum logic [1:0] {
    CFG_KEY_TEXT,
    CFG_KEY_LENGTH,
    CFG_MAX_LENGTH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_SKIP,
    MODE_VALUE,
    MODE_DONE
  } scan_mode_t;

  typedef struct packed {
    logic [63:0] key_text;
    logic [3:0]  key_length;
    logic [6:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       last;
    logic       found;
  } result_t;

  typedef struct packed {
    scan_mode_t mode;
    logic [6:0] emitted;
  } step_status_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // base-16 parse of a two byte escape: optional space or sign, then digits
  function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] d1;
    logic [4:0] d2;
    logic [7:0] r;
    d1 = hex_digit(c1);
    d2 = hex_digit(c2);
    r  = 8'd0;
    if (is_space(c1) || c1 == CH_PLUS) begin
      if (d2[4]) r = {4'd0, d2[3:0]};
    end else if (c1 == CH_MINUS) begin
      if (d2[4]) r = 8'd0 - {4'd0, d2[3:0]};
    end else if (d1[4]) begin
      r = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

>>> rtl/ffe_step.sv
module ffe_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           body_byte,
  input  logic                 end_of_body,
  input  ffe_pkg::cfg_t        cfg,
  output logic [1:0]           push_n,
  output ffe_pkg::result_t     push_words [ffe_pkg::RES_PER_WORD],
  output ffe_pkg::step_status_t status
);

  ffe_pkg::scan_mode_t mode, mode_next;
  logic [3:0] match_index, match_index_next;
  logic [7:0] held0, held0_next;
  logic [1:0] held_count, held_count_next;
  logic [6:0] emitted, emitted_next;
  logic       key_found, key_found_next;

  logic [3:0] klen;
  logic [6:0] lim;
  logic [7:0] kc;
  logic       w0, w1, g0, g1;
  logic [7:0] e0, e1;
  logic [6:0] em1;
  logic       clr;
  ffe_pkg::result_t res_last;

  always_comb begin
    mode_next        = mode;
    match_index_next = match_index;
    held0_next       = held0;
    held_count_next  = held_count;
    key_found_next   = key_found;
    w0  = 1'b0;
    w1  = 1'b0;
    e0  = ffe_pkg::CH_PERCENT;
    e1  = ffe_pkg::plain_byte(held0);
    clr = 1'b0;

    klen = (cfg.key_length > 4'(ffe_pkg::MAX_KEY_BYTES)) ?
           4'(ffe_pkg::MAX_KEY_BYTES) : cfg.key_length;
    lim  = (cfg.max_length > 7'(ffe_pkg::MAX_VALUE_BYTES)) ?
           7'(ffe_pkg::MAX_VALUE_BYTES) : cfg.max_length;
    kc   = cfg.key_text[{match_index[2:0], 3'b000} +: 8];

    if (end_of_body || body_byte == 8'd0) begin
      if (mode == ffe_pkg::MODE_VALUE) begin
        w0 = (held_count != 2'd0);
        w1 = (held_count >= 2'd2);
        held_count_next = 2'd0;
      end
      if (end_of_body) begin
        clr              = 1'b1;
        mode_next        = ffe_pkg::MODE_MATCH;
        match_index_next = 4'd0;
        held0_next       = 8'd0;
        held_count_next  = 2'd0;
        key_found_next   = 1'b0;
      end else begin
        mode_next = ffe_pkg::MODE_DONE;
      end
    end else begin
      case (mode)
        ffe_pkg::MODE_MATCH: begin
          if (match_index < klen) begin
            if (body_byte == kc) match_index_next = match_index + 4'd1;
            else if (body_byte == ffe_pkg::CH_AMP) match_index_next = 4'd0;
            else mode_next = ffe_pkg::MODE_SKIP;
          end else if (body_byte == ffe_pkg::CH_EQUAL) begin
            mode_next      = ffe_pkg::MODE_VALUE;
            key_found_next = 1'b1;
          end else if (body_byte == ffe_pkg::CH_AMP) begin
            match_index_next = 4'd0;
          end else begin
            mode_next = ffe_pkg::MODE_SKIP;
          end
        end
        ffe_pkg::MODE_SKIP: begin
          if (body_byte == ffe_pkg::CH_AMP) begin
            mode_next        = ffe_pkg::MODE_MATCH;
            match_index_next = 4'd0;
          end
        end
        ffe_pkg::MODE_VALUE: begin
          if (body_byte == ffe_pkg::CH_AMP) begin
            w0 = (held_count != 2'd0);
            w1 = (held_count >= 2'd2);
            held_count_next = 2'd0;
            mode_next       = ffe_pkg::MODE_DONE;
          end else if (held_count == 2'd1) begin
            held0_next      = body_byte;
            held_count_next = 2'd2;
          end else if (held_count >= 2'd2) begin
            w0 = 1'b1;
            e0 = ffe_pkg::decode_pair(held0, body_byte);
            held_count_next = 2'd0;
          end else if (body_byte == ffe_pkg::CH_PERCENT) begin
            held_count_next = 2'd1;
          end else begin
            w0 = 1'b1;
            e0 = ffe_pkg::plain_byte(body_byte);
          end
        end
        default: begin
        end
      endcase
    end

    // length limit applied per emitted byte, in order
    g0  = w0 && (emitted < lim);
    em1 = emitted + 7'(g0);
    g1  = w1 && (em1 < lim);
    emitted_next = clr ? 7'd0 : (em1 + 7'(g1));

    res_last = '{value_byte: 8'd0, byte_valid: 1'b0, last: 1'b1, found: key_found};
    push_words[0] = res_last;
    push_words[1] = res_last;
    push_words[2] = res_last;
    if (g0) push_words[0] = '{value_byte: e0, byte_valid: 1'b1, last: 1'b0, found: 1'b0};
    if (g1) push_words[g0 ? 1 : 0] =
              '{value_byte: e1, byte_valid: 1'b1, last: 1'b0, found: 1'b0};
    if (g0 && g1) push_words[2] = res_last;
    push_n = fire ? (2'(g0) + 2'(g1) + 2'(end_of_body)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ffe_pkg::MODE_MATCH;
      match_index <= 4'd0;
      held0       <= 8'd0;
      held_count  <= 2'd0;
      emitted     <= 7'd0;
      key_found   <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      match_index <= match_index_next;
      held0       <= held0_next;
      held_count  <= held_count_next;
      emitted     <= emitted_next;
      key_found   <= key_found_next;
    end
  end

  assign status = '{mode: mode, emitted: emitted};

endmodule

>>> rtl/ffe_res_fifo.sv
module ffe_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  ffe_pkg::result_t push_words [ffe_pkg::RES_PER_WORD],
  input  logic             pop,
  output ffe_pkg::result_t head,
  output logic             not_empty,
  output logic [2:0]       count
);

  ffe_pkg::result_t mem [ffe_pkg::RES_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       do_pop;

  assign not_empty = (count != 3'd0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < ffe_pkg::RES_PER_WORD; i++) begin
      if (2'(i) < push_n) mem[wr_ptr + 2'(i)] <= push_words[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + 2'(do_pop);
      count  <= count + 3'(push_n) - 3'(do_pop);
    end
  end

endmodule

>>> rtl/form_field_extract_url_decode.sv
// Form field extractor with URL decoding.
// Input channel (in_valid/in_ready): one word per body byte, body_byte plus
// end_of_body; a zero body_byte ends the value, end_of_body closes the body.
// Output channel (out_valid/out_ready): one word per result: a decoded value
// byte (byte_valid), or the closing word (last, found) for each end_of_body.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 key_text,
// 1 key_length, 2 max_length; always ready. The user must write it only
// while idle; the block does not enforce this. An accepted word waits in
// the input register until the result queue has room for its results.
// Throughput: one input word per cycle while each word yields at most one
// result and the receiver keeps up; a word is processed only when the
// four-entry result queue holds at most one entry, since a word can yield up
// to three results (two flushed value bytes and the closing word).
// Stall: when out_ready is low, results wait in the queue, then the input
// register fills and in_ready drops; nothing is lost or repeated.
// Reset: queue and input register empty, scan state cleared, registers take
// key text "ssid", key_length 4 and max_length 32.
module form_field_extract_url_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  body_byte,
  input  logic        end_of_body,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  value_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ffe_pkg::cfg_t cfg;
  logic          in_full;
  logic [7:0]    in_byte;
  logic          in_eob;
  logic          fire;
  logic [1:0]    push_n;
  logic [2:0]    fifo_count;
  ffe_pkg::result_t     push_words [ffe_pkg::RES_PER_WORD];
  ffe_pkg::result_t     head;
  ffe_pkg::step_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_text   <= ffe_pkg::KEY_TEXT_RST;
      cfg.key_length <= ffe_pkg::KEY_LENGTH_RST;
      cfg.max_length <= ffe_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffe_pkg::CFG_KEY_TEXT:   cfg.key_text   <= cfg_data;
        ffe_pkg::CFG_KEY_LENGTH: cfg.key_length <= cfg_data[3:0];
        ffe_pkg::CFG_MAX_LENGTH: cfg.max_length <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  assign fire     = in_full &&
                    (fifo_count <= 3'(ffe_pkg::RES_DEPTH - ffe_pkg::RES_PER_WORD));
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= body_byte;
      in_eob  <= end_of_body;
    end
  end

  ffe_step u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .body_byte   (in_byte),
    .end_of_body (in_eob),
    .cfg         (cfg),
    .push_n      (push_n),
    .push_words  (push_words),
    .status      (status)
  );

  ffe_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push_words (push_words),
    .pop        (out_ready),
    .head       (head),
    .not_empty  (out_valid),
    .count      (fifo_count)
  );

  assign value_byte = head.value_byte;
  assign byte_valid = head.byte_valid;
  assign last       = head.last;
  assign found      = head.found;

`include "form_field_extract_url_decode_assert.svh"

  `FFE_ASSERT_NEXT(a_eob_clears, fire && in_eob,
    status.mode == ffe_pkg::MODE_MATCH && status.emitted == 7'd0,
    "end of body did not clear scan state")

  `FFE_ASSERT_NEXT(a_eob_queued, fire && in_eob, fifo_count != 3'd0,
    "closing word not queued")

  `FFE_ASSERT_NOW(a_queue_bound, 1'b1,
    fifo_count <= 3'(ffe_pkg::RES_DEPTH),
    "result queue overflow")

endmodule

>>> bench/tb_form_field_extract_url_decode.sv
module tb_form_field_extract_url_decode;
  import ffe_pkg::*;

  class field_value_checker;
    logic [63:0] key_text;
    logic [3:0]  key_len;
    logic [6:0]  max_len;
    scan_mode_t  mode;
    int unsigned key_pos;
    logic [7:0]  held_char;
    int unsigned held_n;
    int unsigned sent_n;
    bit          key_seen;
    result_t     due_words[$];
    int unsigned errors;

    function new();
      key_text = KEY_TEXT_RST;
      key_len  = KEY_LENGTH_RST;
      max_len  = MAX_LENGTH_RST;
      errors   = 0;
      clear_body();
    endfunction

    function void clear_body();
      mode      = MODE_MATCH;
      key_pos   = 0;
      held_char = 8'h00;
      held_n    = 0;
      sent_n    = 0;
      key_seen  = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] d);
      case (idx)
        CFG_KEY_TEXT:   key_text = d;
        CFG_KEY_LENGTH: key_len  = d[3:0];
        CFG_MAX_LENGTH: max_len  = d[6:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b);
      int unsigned lim;
      lim = max_len > MAX_VALUE_BYTES ? MAX_VALUE_BYTES : max_len;
      if (sent_n >= lim) return;
      sent_n++;
      due_words.push_back({b, 1'b1, 1'b0, 1'b0});
    endfunction

    function void push_plain(logic [7:0] b);
      push_byte(b == CH_PLUS ? CH_SPACE : b);
    endfunction

    function void flush_held();
      if (held_n >= 1) push_byte(CH_PERCENT);
      if (held_n >= 2) push_plain(held_char);
      held_n = 0;
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void take_body_byte(logic [7:0] b, logic eob);
      int unsigned klen;
      int          d1;
      int          d2;
      logic [7:0]  v;
      klen = key_len > MAX_KEY_BYTES ? MAX_KEY_BYTES : key_len;
      if (eob) begin
        if (mode == MODE_VALUE) flush_held();
        due_words.push_back({8'h00, 1'b0, 1'b1, key_seen});
        clear_body();
        return;
      end
      if (b == 8'h00) begin
        if (mode == MODE_VALUE) flush_held();
        mode = MODE_DONE;
        return;
      end
      case (mode)
        MODE_MATCH: begin
          if (key_pos < klen) begin
            if (b == key_text[key_pos*8 +: 8]) key_pos++;
            else if (b == CH_AMP) key_pos = 0;
            else mode = MODE_SKIP;
          end else if (b == CH_EQUAL) begin
            mode = MODE_VALUE;
            key_seen = 1'b1;
          end else if (b == CH_AMP) begin
            key_pos = 0;
          end else begin
            mode = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (b == CH_AMP) begin
            mode = MODE_MATCH;
            key_pos = 0;
          end
        end
        MODE_VALUE: begin
          if (b == CH_AMP) begin
            flush_held();
            mode = MODE_DONE;
          end else if (held_n == 1) begin
            held_char = b;
            held_n = 2;
          end else if (held_n >= 2) begin
            // strtol-style base 16 on the pair
            d1 = hex_val(held_char);
            d2 = hex_val(b);
            v = 8'h00;
            if (held_char == CH_SPACE || held_char == CH_PLUS ||
                (held_char >= 8'd9 && held_char <= 8'd13)) begin
              if (d2 >= 0) v = 8'(d2);
            end else if (held_char == CH_MINUS) begin
              if (d2 >= 0) v = 8'(-d2);
            end else if (d1 >= 0) begin
              v = d2 >= 0 ? 8'(d1 * 16 + d2) : 8'(d1);
            end
            push_byte(v);
            held_n = 0;
          end else if (b == CH_PERCENT) begin
            held_n = 1;
          end else begin
            push_plain(b);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        errors++;
        $error("result word with nothing expected: %p", got);
        return;
      end
      want = due_words.pop_front();
      if (got.value_byte !== want.value_byte) begin
        errors++;
        $error("value_byte expected %02h actual %02h", want.value_byte, got.value_byte);
      end
      if (got.byte_valid !== want.byte_valid) begin
        errors++;
        $error("byte_valid expected %0b actual %0b", want.byte_valid, got.byte_valid);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last expected %0b actual %0b", want.last, got.last);
      end
      if (got.found !== want.found) begin
        errors++;
        $error("found expected %0b actual %0b", want.found, got.found);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  body_byte;
  logic        end_of_body;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  value_byte;
  logic        byte_valid;
  logic        last;
  logic        found;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  field_value_checker checker_q;
  logic [7:0]  body_q[$];
  bit          steady = 1'b0;
  int unsigned stall_reqs = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;

  form_field_extract_url_decode u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .body_byte   (body_byte),
    .end_of_body (end_of_body),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_byte  (value_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .found       (found),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted words, random back-pressure, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) checker_q.check_word({value_byte, byte_valid, last, found});
      if (stall_served != stall_reqs) begin
        stall_served++;
        stall_left = 80;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic e);
    if (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid    <= 1'b1;
    body_byte   <= b;
    end_of_body <= e;
    do @(posedge clk); while (!in_ready);
    checker_q.take_body_byte(b, e);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    checker_q.set_reg(idx, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (checker_q.due_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [7:0] pair_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 8'($urandom_range(48, 57));
    if (r < 40) return 8'($urandom_range(97, 102));
    if (r < 60) return 8'($urandom_range(65, 70));
    if (r < 66) return CH_SPACE;
    if (r < 70) return 8'($urandom_range(9, 13));
    if (r < 75) return CH_PLUS;
    if (r < 80) return CH_MINUS;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [63:0] letters_key();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[i*8 +: 8] = 8'($urandom_range(97, 122));
    return k;
  endfunction

  // mostly well-formed bodies: params joined by '&', key (exact, cut, damaged or other) '=' value
  task automatic build_body();
    int unsigned nparams;
    int unsigned klen;
    int unsigned cut;
    int unsigned vlen;
    int unsigned r;
    logic [7:0]  c;
    body_q.delete();
    klen = checker_q.key_len > MAX_KEY_BYTES ? MAX_KEY_BYTES : checker_q.key_len;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(10)) body_q.push_back(8'($urandom_range(255)));
      return;
    end
    nparams = $urandom_range(1, 4);
    for (int p = 0; p < nparams; p++) begin
      if (p != 0) body_q.push_back(CH_AMP);
      r = $urandom_range(99);
      cut = r < 60 ? klen : r < 70 ? $urandom_range(klen) : r < 80 ? klen : 0;
      for (int i = 0; i < cut; i++) body_q.push_back(checker_q.key_text[i*8 +: 8]);
      if (r >= 70 && r < 80 && cut != 0)
        body_q[body_q.size() - 1 - $urandom_range(cut - 1)] ^= 8'(1 << $urandom_range(7));
      if (r >= 80) repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(97, 122)));
      if ($urandom_range(99) < 92) body_q.push_back(CH_EQUAL);
      vlen = $urandom_range(99) < 5 ? $urandom_range(60, 70) : $urandom_range(8);
      repeat (vlen) begin
        r = $urandom_range(99);
        if (r < 25) begin
          body_q.push_back(CH_PERCENT);
          body_q.push_back(pair_char());
          body_q.push_back(pair_char());
        end else if (r < 35) begin
          body_q.push_back(CH_PLUS);
        end else if (r < 40) begin
          body_q.push_back(CH_PERCENT);
        end else if (r < 92) begin
          c = 8'($urandom_range(33, 126));
          body_q.push_back(c == CH_AMP ? CH_SPACE : c);
        end else begin
          body_q.push_back(8'($urandom_range(1, 255)));
        end
      end
    end
    if ($urandom_range(99) < 5) body_q.insert($urandom_range(body_q.size()), 8'h00);
  endtask

  task automatic run_phase(input logic [63:0] key, input logic [3:0] klen,
                           input logic [6:0] mlen, input bit calm, input bit hold,
                           input int unsigned words);
    int unsigned sent;
    bit          held_off;
    write_reg(CFG_KEY_TEXT, key);
    write_reg(CFG_KEY_LENGTH, 64'(klen));
    write_reg(CFG_MAX_LENGTH, 64'(mlen));
    cfg_valid <= 1'b0;
    steady = calm;
    sent = 0;
    held_off = 1'b0;
    while (sent < words) begin
      if (hold && !held_off && sent >= 8) begin
        stall_reqs++;
        held_off = 1'b1;
      end
      build_body();
      // keep the phase close to its word budget
      while (body_q.size() > words - sent) void'(body_q.pop_back());
      for (int i = 0; i < body_q.size(); i++) send_word(body_q[i], 1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
      sent += body_q.size() + 1;
    end
    drain();
    steady = 1'b0;
  endtask

  initial begin
    string s;
    checker_q   = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    body_byte   <= 8'h00;
    end_of_body <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_KEY_TEXT;
    cfg_data    <= 64'h0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset key: escapes, plus, signed pair, space pair, dangling percent
    s = "ssid=%41+%-A% 7%";
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    send_word(8'h00, 1'b1);
    // '&' restart, all-ones byte, zero byte stops the scan, key never seen
    send_word(CH_AMP, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    drain();

    run_phase(64'h6b, 4'd1, 7'd1, 1'b0, 1'b0, 40);
    run_phase(letters_key(), 4'd8, 7'd64, 1'b1, 1'b0, 50);
    run_phase({$urandom, $urandom}, 4'($urandom_range(1, 8)), 7'($urandom_range(1, 64)),
              1'b0, 1'b1, 40);
    run_phase('1, 4'd8, 7'd64, 1'b0, 1'b0, 30);
    run_phase('0, 4'd1, 7'd2, 1'b0, 1'b0, 20);
    run_phase(letters_key(), 4'd3, 7'd4, 1'b0, 1'b1, 40);
    repeat (2)
      run_phase(letters_key(), 4'($urandom_range(1, 8)), 7'($urandom_range(1, 64)),
                1'b0, 1'b0, 40);

    if (checker_q.errors == 0 && checker_q.due_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/ffe_pkg.sv
rtl/ffe_step.sv
rtl/ffe_res_fifo.sv
rtl/form_field_extract_url_decode.sv
bench/tb_form_field_extract_url_decode.sv
